/* rtl/ted_pkg.sv */
package ted_pkg;

  localparam int COUNT_BITS = 16;
  localparam int THR_BITS   = 16;
  localparam int OUT_BITS   = 16;

  typedef enum logic [2:0] {
    VERDICT_ANSI  = 3'd0,
    VERDICT_UTF8  = 3'd1,
    VERDICT_LE    = 3'd2,
    VERDICT_BE    = 3'd3,
    VERDICT_U8BOM = 3'd4
  } verdict_t;

  localparam logic [2:0] MARK_LE  = 3'b001;
  localparam logic [2:0] MARK_BE  = 3'b010;
  localparam logic [2:0] MARK_U8  = 3'b100;
  localparam logic [2:0] MARK_ALL = 3'b111;

  localparam logic [7:0] BYTE_FF = 8'hFF;
  localparam logic [7:0] BYTE_FE = 8'hFE;
  localparam logic [7:0] BYTE_EF = 8'hEF;
  localparam logic [7:0] BYTE_BB = 8'hBB;
  localparam logic [7:0] BYTE_BF = 8'hBF;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [1:0]            pos;
    logic [2:0]            marks;
    logic [1:0]            cont_left;
    logic [COUNT_BITS-1:0] count;
    verdict_t              held_verdict;
    logic                  held_valid;
    logic                  sent;
  } ted_state_t;

  localparam ted_state_t STATE_CLEAR = '{
    pos:          2'd0,
    marks:        MARK_ALL,
    cont_left:    2'd0,
    count:        '0,
    held_verdict: VERDICT_ANSI,
    held_valid:   1'b0,
    sent:         1'b0
  };

  typedef struct packed {
    logic                emit;
    verdict_t            verdict;
    logic [OUT_BITS-1:0] count;
  } ted_result_t;

endpackage

/* rtl/ted_step.sv */
module ted_step
  import ted_pkg::*;
(
  input  ted_state_t          state_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  input  logic [THR_BITS-1:0] threshold_i,
  output ted_state_t          state_o,
  output ted_result_t         res_o
);

  function automatic logic [2:0] lead_ones(input logic [7:0] b);
    logic [2:0] n;
    begin
      if (!b[6]) begin
        n = 3'd1;
      end else if (!b[5]) begin
        n = 3'd2;
      end else if (!b[4]) begin
        n = 3'd3;
      end else if (!b[3]) begin
        n = 3'd4;
      end else begin
        n = 3'd5;
      end
      return n;
    end
  endfunction

  ted_state_t  st;
  ted_result_t res;
  logic [2:0]  keep;
  logic [2:0]  n_ones;
  logic [1:0]  left_dec;

  always_comb begin
    st       = state_i;
    res      = '0;
    keep     = '0;
    n_ones   = lead_ones(data_byte_i);
    left_dec = state_i.cont_left - 2'd1;

    if (!state_i.sent) begin
      case (state_i.pos)
        2'd0: begin
          keep[0] = (data_byte_i == BYTE_FF);
          keep[1] = (data_byte_i == BYTE_FE);
          keep[2] = (data_byte_i == BYTE_EF);
          st.marks = st.marks & keep;
        end
        2'd1: begin
          keep[0] = (data_byte_i == BYTE_FE);
          keep[1] = (data_byte_i == BYTE_FF);
          keep[2] = (data_byte_i == BYTE_BB);
          st.marks = st.marks & keep;
          if ((st.marks & MARK_LE) != '0) begin
            st.held_verdict = VERDICT_LE;
            st.held_valid   = 1'b1;
            st.marks        = '0;
          end else if ((st.marks & MARK_BE) != '0) begin
            st.held_verdict = VERDICT_BE;
            st.held_valid   = 1'b1;
            st.marks        = '0;
          end else begin
            st.marks = st.marks & MARK_U8;
          end
        end
        2'd2: begin
          if (((st.marks & MARK_U8) != '0) && (data_byte_i == BYTE_BF)) begin
            st.held_verdict = VERDICT_U8BOM;
            st.held_valid   = 1'b1;
          end
          st.marks = '0;
        end
        default: begin
          st.marks = '0;
        end
      endcase

      if (!st.held_valid) begin
        if (state_i.cont_left != 2'd0) begin
          if (data_byte_i[7:6] != 2'b10) begin
            st.held_verdict = VERDICT_ANSI;
            st.held_valid   = 1'b1;
          end else begin
            st.cont_left = left_dec;
            if (left_dec == 2'd0) begin
              if (st.count != COUNT_MAX) begin
                st.count = st.count + COUNT_BITS'(1);
              end
              if (32'(st.count) >= 32'(threshold_i)) begin
                st.held_verdict = VERDICT_UTF8;
                st.held_valid   = 1'b1;
              end
            end
          end
        end else if (data_byte_i[7]) begin
          if ((n_ones == 3'd1) || (n_ones > 3'd4)) begin
            st.held_verdict = VERDICT_ANSI;
            st.held_valid   = 1'b1;
          end else begin
            st.cont_left = 2'(n_ones - 3'd1);
          end
        end
      end

      if (st.pos != 2'd3) begin
        st.pos = st.pos + 2'd1;
      end

      if (st.held_valid && ((st.marks == '0) || last_byte_i)) begin
        res.emit    = 1'b1;
        res.verdict = st.held_verdict;
        if ((st.held_verdict == VERDICT_LE) || (st.held_verdict == VERDICT_BE) ||
            (st.held_verdict == VERDICT_U8BOM)) begin
          res.count = '0;
        end else begin
          res.count = OUT_BITS'(st.count);
        end
        st.sent = 1'b1;
      end else if (last_byte_i) begin
        res.emit    = 1'b1;
        res.verdict = VERDICT_ANSI;
        res.count   = OUT_BITS'(st.count);
        st.sent     = 1'b1;
      end
    end

    if (last_byte_i) begin
      st = STATE_CLEAR;
    end
  end

  assign state_o = st;
  assign res_o   = res;

endmodule

/* rtl/text_encoding_detector_core.sv */
// Text encoding detector. Bytes of a buffer enter on the input channel, one per
// transaction, with in_last_byte marking the buffer's final byte; each buffer yields
// exactly one result transaction. A byte-order mark at the start of the buffer (FF FE,
// FE FF, EF BB BF) wins; otherwise the UTF-8 scan decides UTF8 once cfg_wr_data's
// threshold of complete multibyte sequences is reached, local ANSI on any malformed
// byte, and local ANSI at the buffer's end if nothing was decided. The result can
// leave before the last byte; the remaining bytes of that buffer are absorbed. The
// block takes one byte every clock cycle while in_ready is high. The per-byte state
// update is one short step of logic ahead of the state registers, and the deciding
// byte's result is registered in the output register or, while the output is
// stalled, in one skid entry; input only stops when both are full.
module text_encoding_detector_core
  import ted_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [THR_BITS-1:0] cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_verdict,
  output logic [OUT_BITS-1:0] out_valid_sequences
);

  logic [THR_BITS-1:0] threshold_r;
  ted_state_t          state_r;
  ted_state_t          state_nxt;
  ted_result_t         step_res;
  ted_result_t         out_r;
  ted_result_t         out_nxt;
  ted_result_t         skid_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                skid_valid_r;
  logic                skid_valid_nxt;
  logic                accept;
  logic                produce;

  ted_step u_step (
    .state_i     (state_r),
    .data_byte_i (in_data_byte),
    .last_byte_i (in_last_byte),
    .threshold_i (threshold_r),
    .state_o     (state_nxt),
    .res_o       (step_res)
  );

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign produce  = accept && step_res.emit;

  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (produce) begin
        out_nxt       = step_res;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (produce) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THR_BITS'(1);
      state_r      <= STATE_CLEAR;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        threshold_r <= cfg_wr_data;
      end
      if (accept) begin
        state_r <= state_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (produce && out_valid_r && !out_ready) begin
      skid_r <= step_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_verdict         = out_r.verdict;
  assign out_valid_sequences = out_r.count;

endmodule

/* rtl/ted_checker.sv */
module ted_checker
  import ted_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [2:0]          out_verdict,
  input logic [OUT_BITS-1:0] out_valid_sequences
);

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict <= VERDICT_U8BOM))
    else $error("Unknown verdict code.");

  a_bom_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_verdict == VERDICT_LE) || (out_verdict == VERDICT_BE) ||
                  (out_verdict == VERDICT_U8BOM)) |-> (out_valid_sequences == '0))
    else $error("Byte-order-mark verdict carries a sequence count.");

  a_utf8_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict == VERDICT_UTF8) |-> (out_valid_sequences != '0))
    else $error("UTF8 verdict without any valid sequence.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict) &&
                                 $stable(out_valid_sequences))
    else $error("Stalled result transaction changed.");

endmodule

bind text_encoding_detector_core ted_checker u_ted_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_verdict         (out_verdict),
  .out_valid_sequences (out_valid_sequences)
);
